/* rtl/atma_pkg.sv */
`default_nettype none

package atma_pkg;

  localparam int DEPTH          = 10;
  localparam int AIR_TIME_W     = 32;
  localparam int SAMPLE_COUNT_W = 4;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int POS_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOTAL_W        = AIR_TIME_W + $clog2(DEPTH + 1);
  localparam int STEP_W         = $clog2(TOTAL_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUB,
    S_ADD,
    S_START,
    S_DIVIDE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic read;
    logic write;
  } ring_ctl_t;

endpackage

`default_nettype wire

/* rtl/atma_divider.sv */
`default_nettype none

module atma_divider
  import atma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [TOTAL_W-1:0] quotient
);

  logic               busy;
  logic [STEP_W-1:0]  step_count;
  logic [TOTAL_W-1:0] quo;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   dvs;

  logic [CNT_W:0]     rem_shift;
  logic [CNT_W:0]     diff;
  logic               fits;
  logic [CNT_W-1:0]   rem_next;
  logic [TOTAL_W-1:0] quo_next;

  always_comb begin
    rem_shift = {rem, quo[TOTAL_W-1]};
    diff      = rem_shift - {1'b0, dvs};
    fits      = (rem_shift >= {1'b0, dvs});
    rem_next  = fits ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    quo_next  = {quo[TOTAL_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      step_count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        step_count <= '0;
      end else if (busy) begin
        step_count <= step_count + STEP_W'(1);
        if (step_count == STEP_W'(TOTAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* rtl/atma_ring.sv */
`default_nettype none

module atma_ring
  import atma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ring_ctl_t             ctl,
  input  logic [AIR_TIME_W-1:0] wr_data,
  output logic [AIR_TIME_W-1:0] old_sample,
  output logic [CNT_W-1:0]      count
);

  logic [AIR_TIME_W-1:0] mem [DEPTH];
  logic [AIR_TIME_W-1:0] rd_data;
  logic                  old_valid;
  logic [POS_W-1:0]      pos;

  // Slots fill in order from reset, so the slot being replaced holds a
  // sample only once the ring is full; before that it reads as zero.
  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rd_data   <= mem[pos];
      old_valid <= (count == CNT_W'(DEPTH));
    end
    if (ctl.write) begin
      mem[pos] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      count <= '0;
    end else if (ctl.write) begin
      pos <= (pos == POS_W'(DEPTH - 1)) ? '0 : pos + POS_W'(1);
      if (count != CNT_W'(DEPTH)) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  assign old_sample = old_valid ? rd_data : '0;

endmodule

`default_nettype wire

/* rtl/air_time_moving_average_unit.sv */
`default_nettype none

// Moving average of transmit air time. Each item carries one air-time sample;
// it replaces the oldest of the last ten samples and the unit returns the
// truncated mean of the samples held together with how many are held
// (one to ten). The mean is formed by a bit-serial divider that produces one
// quotient bit per cycle over the 36-bit running total. The unit takes one
// item at a time and is ready again once the previous result has moved
// into the output register.
module air_time_moving_average_unit
  import atma_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic [AIR_TIME_W-1:0]     air_time,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [AIR_TIME_W-1:0]     average_air_time,
  output logic [SAMPLE_COUNT_W-1:0] sample_count
);

  state_t state;
  state_t state_next;

  logic [AIR_TIME_W-1:0] sample;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    total_next;
  logic [TOTAL_W-1:0]    operand;

  logic [AIR_TIME_W-1:0] old_sample;
  logic [CNT_W-1:0]      count;
  logic                  div_done;
  logic [TOTAL_W-1:0]    quotient;

  ring_ctl_t ring_ctl;
  logic      acc_en;
  logic      acc_sub;
  logic      div_start;
  logic      out_load;
  logic      accept;

  assign accept = sample_valid && sample_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (sample_valid) state_next = S_READ;
      S_READ:   state_next = S_SUB;
      S_SUB:    state_next = S_ADD;
      S_ADD:    state_next = S_START;
      S_START:  state_next = S_DIVIDE;
      S_DIVIDE: if (div_done) state_next = S_HOLD;
      S_HOLD:   if (!result_valid || result_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready   = 1'b0;
    ring_ctl.read  = 1'b0;
    ring_ctl.write = 1'b0;
    acc_en         = 1'b0;
    acc_sub        = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    case (state)
      S_IDLE:   sample_ready = 1'b1;
      S_READ:   ring_ctl.read = 1'b1;
      S_SUB: begin
        acc_en  = 1'b1;
        acc_sub = 1'b1;
      end
      S_ADD: begin
        acc_en         = 1'b1;
        ring_ctl.write = 1'b1;
      end
      S_START:  div_start = 1'b1;
      S_DIVIDE: ;
      S_HOLD:   out_load = !result_valid || result_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One adder serves both steps of the total update.
  always_comb begin
    operand    = acc_sub ? ~{{(TOTAL_W - AIR_TIME_W){1'b0}}, old_sample}
                         : {{(TOTAL_W - AIR_TIME_W){1'b0}}, sample};
    total_next = total + operand + TOTAL_W'(acc_sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (acc_en) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= air_time;
    end
  end

  atma_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ring_ctl),
    .wr_data    (sample),
    .old_sample (old_sample),
    .count      (count)
  );

  atma_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_air_time <= quotient[AIR_TIME_W-1:0];
      sample_count     <= SAMPLE_COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

/* rtl/atma_checker.sv */
`default_nettype none

module atma_checker
  import atma_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_valid,
  input logic                      sample_ready,
  input logic [AIR_TIME_W-1:0]     air_time,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [AIR_TIME_W-1:0]     average_air_time,
  input logic [SAMPLE_COUNT_W-1:0] sample_count
);

  logic unused_ok;

  assign unused_ok = ^air_time;

  // A result that is not taken stays on the port unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(average_air_time) && $stable(sample_count))
    else $error("result changed while stalled");

  // Every result follows at least one stored sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (sample_count != '0) || (DEPTH >= 16))
    else $error("result shows an empty sample count");

  // The unit works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second item taken while busy");

  // Reset leaves the unit ready with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> sample_ready && !result_valid)
    else $error("unit not idle after reset");

endmodule

bind air_time_moving_average_unit atma_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample_valid),
  .sample_ready     (sample_ready),
  .air_time         (air_time),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .average_air_time (average_air_time),
  .sample_count     (sample_count)
);

`default_nettype wire

/* bench/air_time_mean_tracker.sv */
`default_nettype none

module air_time_mean_tracker
  import atma_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      sample_valid,
  input  wire logic                      sample_ready,
  input  wire logic [AIR_TIME_W-1:0]     air_time,
  input  wire logic                      result_valid,
  input  wire logic                      result_ready,
  input  wire logic [AIR_TIME_W-1:0]     average_air_time,
  input  wire logic [SAMPLE_COUNT_W-1:0] sample_count,
  output int                             failures,
  output int                             pending
);

  typedef struct packed {
    logic [AIR_TIME_W-1:0]     average;
    logic [SAMPLE_COUNT_W-1:0] count;
  } air_time_mean_t;

  logic [AIR_TIME_W-1:0] window [DEPTH];
  logic [TOTAL_W-1:0]    window_total;
  int                    slot;
  int                    held;
  air_time_mean_t        expected_means [$];
  int                    fail_count = 0;
  int                    waiting = 0;

  assign failures = fail_count;
  assign pending  = waiting;

  always @(posedge clk) begin
    logic [TOTAL_W-1:0] quotient;
    air_time_mean_t     oldest;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) window[i] = '0;
      window_total = '0;
      slot = 0;
      held = 0;
      expected_means.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_means.size() == 0) begin
          $error("result item with no item outstanding: average_air_time %0d sample_count %0d",
                 average_air_time, sample_count);
          fail_count++;
        end else begin
          oldest = expected_means.pop_front();
          if (average_air_time !== oldest.average) begin
            $error("average_air_time expected %0d actual %0d", oldest.average,
                   average_air_time);
            fail_count++;
          end
          if (sample_count !== oldest.count) begin
            $error("sample_count expected %0d actual %0d", oldest.count, sample_count);
            fail_count++;
          end
        end
      end
      if (sample_valid && sample_ready) begin
        window_total = window_total - TOTAL_W'(window[slot]) + TOTAL_W'(air_time);
        window[slot] = air_time;
        slot = (slot == DEPTH - 1) ? 0 : slot + 1;
        if (held < DEPTH) held++;
        quotient = window_total / TOTAL_W'(held);
        oldest.average = quotient[AIR_TIME_W-1:0];
        oldest.count   = held[SAMPLE_COUNT_W-1:0];
        expected_means.push_back(oldest);
      end
    end
    waiting = expected_means.size();
  end

endmodule

`default_nettype wire

/* bench/tb_air_time_moving_average_unit.sv */
`default_nettype none

module tb_air_time_moving_average_unit;
  import atma_pkg::*;

  localparam int RANDOM_SAMPLES = 1350;

  logic                      clk;
  logic                      rst;
  logic                      sample_valid;
  logic                      sample_ready;
  logic [AIR_TIME_W-1:0]     air_time;
  logic                      result_valid;
  logic                      result_ready;
  logic [AIR_TIME_W-1:0]     average_air_time;
  logic [SAMPLE_COUNT_W-1:0] sample_count;
  int                        failures;
  int                        pending;
  int                        burst_left;
  int                        stall_left;
  int                        rx_cycle;

  logic [AIR_TIME_W-1:0] directed_samples [0:22] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  air_time_moving_average_unit uut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .air_time         (air_time),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .average_air_time (average_air_time),
    .sample_count     (sample_count)
  );

  air_time_mean_tracker mean_tracker (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .air_time         (air_time),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .average_air_time (average_air_time),
    .sample_count     (sample_count),
    .failures         (failures),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [AIR_TIME_W-1:0] random_air_time();
    logic [AIR_TIME_W-1:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom;
      4:          value = $urandom_range(0, 255);
      5:          value = 32'hFFFF_FFFF - $urandom_range(0, 255);
      6:          value = 32'hFFFF_FFFF;
      7:          value = '0;
      8:          value = 32'h1 << $urandom_range(0, 31);
      default:    value = $urandom >> $urandom_range(1, 31);
    endcase
    return value;
  endfunction

  task automatic send_sample(input logic [AIR_TIME_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        sample_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sample_valid = 1'b1;
    air_time = value;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  initial begin
    result_ready = 1'b0;
    stall_left = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if ((rx_cycle / 3000) % 4 == 3) begin
        result_ready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        result_ready = 1'b0;
        stall_left--;
      end else begin
        result_ready = 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 90);
      end
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    air_time = '0;
    burst_left = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    for (int i = 0; i < RANDOM_SAMPLES; i++) send_sample(random_air_time());
    sample_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
